// ----- src/csaf_pkg.sv -----
// shared types, constants and cordic table for the control surface force block
// no dependencies; imported by csaf_sincos and control_surface_aero_force
`default_nettype none

package csaf_pkg;

	// request and result payloads
	typedef struct packed {
		logic signed [23:0] vel_x;
		logic signed [23:0] vel_y;
		logic signed [15:0] body_angle;
		logic signed [15:0] control_value;
	} item_t;

	typedef struct packed {
		logic signed [47:0] force_x;
		logic signed [47:0] force_y;
	} result_t;

	// register indexes
	localparam logic [2:0] REG_DEFL_STEP   = 3'd0;
	localparam logic [2:0] REG_INCLINATION = 3'd1;
	localparam logic [2:0] REG_ORIENT_NEG  = 3'd2;
	localparam logic [2:0] REG_LIFT_COEFF  = 3'd3;
	localparam logic [2:0] REG_DRAG_H      = 3'd4;
	localparam logic [2:0] REG_DRAG_V      = 3'd5;
	localparam logic [2:0] REG_MAX_VALUE   = 3'd6;
	localparam logic [2:0] REG_MIN_VALUE   = 3'd7;

	localparam logic signed [15:0] MAX_VALUE_RST = 16'sd16384;
	localparam logic signed [15:0] MIN_VALUE_RST = -16'sd16384;

	// cordic sizing
	localparam int CORDIC_STEPS = 15;
	localparam int CW = 34;	// rotation datapath
	localparam int AW = 44;	// vectoring datapath
	localparam int ZW = 18;	// angle accumulator
	localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [ZW-1:0] QUARTER = 18'sd16384;
	localparam logic signed [ZW-1:0] HALF    = 18'sd32768;

	// arctangent of 2^-i in binary angle units
	function automatic logic signed [ZW-1:0] atan_lut(input int i);
		logic signed [ZW-1:0] r;
		case (i)
			0:  r = 18'sd8192;
			1:  r = 18'sd4836;
			2:  r = 18'sd2555;
			3:  r = 18'sd1297;
			4:  r = 18'sd651;
			5:  r = 18'sd326;
			6:  r = 18'sd163;
			7:  r = 18'sd81;
			8:  r = 18'sd41;
			9:  r = 18'sd20;
			10: r = 18'sd10;
			11: r = 18'sd5;
			12: r = 18'sd3;
			13: r = 18'sd1;
			14: r = 18'sd1;
			default: r = 18'sd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- src/csaf_sincos.sv -----
// pipelined rotation cordic giving sine and cosine of a binary angle, Q1.14
// depends on csaf_pkg; advances only while en is high
`default_nettype none

module csaf_sincos (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic signed [15:0] angle,
	output logic signed [15:0]      sin_val,
	output logic signed [15:0]      cos_val
);
	import csaf_pkg::*;

	logic signed [CW-1:0] x_sn [0:CORDIC_STEPS];
	logic signed [CW-1:0] y_sn [0:CORDIC_STEPS];
	logic signed [ZW-1:0] z_sn [0:CORDIC_STEPS];
	logic                 neg_sn [0:CORDIC_STEPS];

	logic signed [ZW-1:0] a_ext, z_fold;
	logic                 neg_fold;
	logic signed [CW-1:0] x_rnd, y_rnd, x_fix, y_fix;

	// fold the angle into the right half plane
	always_comb begin
		a_ext = ZW'(angle);
		z_fold = a_ext;
		neg_fold = 1'b0;
		if (a_ext > QUARTER) begin
			z_fold = a_ext - HALF;
			neg_fold = 1'b1;
		end else if (a_ext < -QUARTER) begin
			z_fold = a_ext + HALF;
			neg_fold = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_sn[0] <= CORDIC_GAIN;
			y_sn[0] <= '0;
			z_sn[0] <= z_fold;
			neg_sn[0] <= neg_fold;
		end
	end

	// one micro-rotation per stage
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
		always_ff @(posedge clk) begin
			if (en) begin
				neg_sn[i+1] <= neg_sn[i];
				if (z_sn[i] >= 0) begin
					x_sn[i+1] <= x_sn[i] - (y_sn[i] >>> i);
					y_sn[i+1] <= y_sn[i] + (x_sn[i] >>> i);
					z_sn[i+1] <= z_sn[i] - atan_lut(i);
				end else begin
					x_sn[i+1] <= x_sn[i] + (y_sn[i] >>> i);
					y_sn[i+1] <= y_sn[i] - (x_sn[i] >>> i);
					z_sn[i+1] <= z_sn[i] + atan_lut(i);
				end
			end
		end
	end

	// round to Q1.14, undo the fold and clamp to unity
	always_comb begin
		x_rnd = (x_sn[CORDIC_STEPS] + CW'(32768)) >>> 16;
		y_rnd = (y_sn[CORDIC_STEPS] + CW'(32768)) >>> 16;
		x_fix = neg_sn[CORDIC_STEPS] ? -x_rnd : x_rnd;
		y_fix = neg_sn[CORDIC_STEPS] ? -y_rnd : y_rnd;
		if (x_fix > CW'(16384))
			x_fix = CW'(16384);
		if (x_fix < -CW'(16384))
			x_fix = -CW'(16384);
		if (y_fix > CW'(16384))
			y_fix = CW'(16384);
		if (y_fix < -CW'(16384))
			y_fix = -CW'(16384);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sin_val <= y_fix[15:0];
			cos_val <= x_fix[15:0];
		end
	end

endmodule

`default_nettype wire

// ----- src/control_surface_aero_force.sv -----
// top level: aerodynamic force of one control surface, fully pipelined
// depends on csaf_pkg and csaf_sincos
`default_nettype none

// Usage
// A request on item_* carries body velocity, body angle and requested
// deflection; one result on result_* carries the world force x and y.
// Configuration registers are written on cfg_* (always ready); the user must
// write them only while the pipeline is empty, which the block does not enforce.
// The pipeline has 40 register stages: two setup stages, a 15-stage vectoring
// cordic for the flow angle, one angle of attack stage, a 17-stage rotation
// cordic pair for sine and cosine, and five multiply and round stages for the forces.
// Throughput is one request per cycle while the receiver does not stall; every
// stage is a register and the multipliers are one per stage per product.
// Reset clears all valid bits and loads the register reset values.
// When the receiver stalls with a result waiting, the whole pipeline
// holds and item_ready drops; nothing is lost or repeated.

module control_surface_aero_force (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_ready,
	input  wire csaf_pkg::item_t  item_data,
	output logic                  result_valid,
	input  wire logic             result_ready,
	output csaf_pkg::result_t     result_data,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [2:0]       cfg_index,
	input  wire logic [15:0]      cfg_data
);
	import csaf_pkg::*;

	localparam int DEPTH = 40;
	localparam int V2_LEN = 34;	// v2 carried from stage 2 to stage 35

	// configuration registers
	logic signed [15:0] step_q, incl_q, max_q, min_q;
	logic               orient_q;
	logic [15:0]        lc_q, dh_q, dv_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			incl_q <= '0;
			orient_q <= 1'b0;
			lc_q <= '0;
			dh_q <= '0;
			dv_q <= '0;
			max_q <= MAX_VALUE_RST;
			min_q <= MIN_VALUE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DEFL_STEP:   step_q <= cfg_data;
				REG_INCLINATION: incl_q <= cfg_data;
				REG_ORIENT_NEG:  orient_q <= cfg_data[0];
				REG_LIFT_COEFF:  lc_q <= cfg_data;
				REG_DRAG_H:      dh_q <= cfg_data;
				REG_DRAG_V:      dv_q <= cfg_data;
				REG_MAX_VALUE:   max_q <= cfg_data;
				REG_MIN_VALUE:   min_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline advance and valid bits
	logic             en;
	logic [DEPTH:1]   vld_sn;

	assign en = !vld_sn[DEPTH] || result_ready;
	assign item_ready = en;
	assign result_valid = vld_sn[DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sn <= '0;
		end else if (en) begin
			vld_sn <= {vld_sn[DEPTH-1:1], item_valid};
		end
	end

	// stage 1: clamp, deflection product, velocity squares
	logic signed [15:0] val_c;
	logic signed [31:0] defl_prod_s1;
	logic signed [23:0] vx_s1, vy_s1;
	logic signed [15:0] body_s1;
	logic signed [47:0] vxsq_s1, vysq_s1;

	always_comb begin
		val_c = item_data.control_value;
		if (val_c > max_q)
			val_c = max_q;
		else if (val_c < min_q)
			val_c = min_q;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			defl_prod_s1 <= val_c * step_q;
			vx_s1 <= item_data.vel_x;
			vy_s1 <= item_data.vel_y;
			body_s1 <= item_data.body_angle;
			vxsq_s1 <= item_data.vel_x * item_data.vel_x;
			vysq_s1 <= item_data.vel_y * item_data.vel_y;
		end
	end

	// stage 2: surface angle, speed squared, vectoring set-up
	logic signed [32:0] surf_round;
	logic signed [15:0] surf_raw, surf_c;
	logic signed [AW-1:0] ax_c, ay_c, ax0, ay0;
	logic signed [ZW-1:0] az0;

	logic signed [AW-1:0] at_x_sn [0:CORDIC_STEPS];
	logic signed [AW-1:0] at_y_sn [0:CORDIC_STEPS];
	logic signed [ZW-1:0] at_z_sn [0:CORDIC_STEPS];
	logic signed [15:0]   surf_sn [0:CORDIC_STEPS];
	logic signed [15:0]   body_sn [0:CORDIC_STEPS];
	logic                 zero_sn [0:CORDIC_STEPS];
	logic [47:0]          v2_sn [0:V2_LEN-1];

	always_comb begin
		surf_round = {defl_prod_s1[31], defl_prod_s1} + 33'sd8192;
		surf_raw = surf_round[29:14] + incl_q;
		surf_c = orient_q ? -surf_raw : surf_raw;
		ax_c = {{(AW-40){vx_s1[23]}}, vx_s1, 16'h0000};
		ay_c = {{(AW-40){vy_s1[23]}}, vy_s1, 16'h0000};
		ax0 = ax_c;
		ay0 = ay_c;
		az0 = '0;
		if (ax_c < 0) begin
			if (ay_c >= 0) begin
				ax0 = ay_c;
				ay0 = -ax_c;
				az0 = QUARTER;
			end else begin
				ax0 = -ay_c;
				ay0 = ax_c;
				az0 = -QUARTER;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			at_x_sn[0] <= ax0;
			at_y_sn[0] <= ay0;
			at_z_sn[0] <= az0;
			surf_sn[0] <= surf_c;
			body_sn[0] <= body_s1;
			zero_sn[0] <= (vx_s1 == '0) && (vy_s1 == '0);
			v2_sn[0] <= 48'(vxsq_s1) + 48'(vysq_s1);
		end
	end

	// stages 3 to 17: vectoring cordic for the flow angle
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
		always_ff @(posedge clk) begin
			if (en) begin
				surf_sn[i+1] <= surf_sn[i];
				body_sn[i+1] <= body_sn[i];
				zero_sn[i+1] <= zero_sn[i];
				if (at_y_sn[i] > 0) begin
					at_x_sn[i+1] <= at_x_sn[i] + (at_y_sn[i] >>> i);
					at_y_sn[i+1] <= at_y_sn[i] - (at_x_sn[i] >>> i);
					at_z_sn[i+1] <= at_z_sn[i] + atan_lut(i);
				end else begin
					at_x_sn[i+1] <= at_x_sn[i] - (at_y_sn[i] >>> i);
					at_y_sn[i+1] <= at_y_sn[i] + (at_x_sn[i] >>> i);
					at_z_sn[i+1] <= at_z_sn[i] - atan_lut(i);
				end
			end
		end
	end

	// speed squared rides along to the force stages
	for (genvar j = 1; j < V2_LEN; j++) begin : g_v2
		always_ff @(posedge clk) begin
			if (en)
				v2_sn[j] <= v2_sn[j-1];
		end
	end

	// stage 18: angle of attack
	logic signed [15:0] flow_c;
	logic signed [15:0] attack_s18, body_s18;

	assign flow_c = zero_sn[CORDIC_STEPS] ? 16'sd0 : at_z_sn[CORDIC_STEPS][15:0];

	always_ff @(posedge clk) begin
		if (en) begin
			attack_s18 <= surf_sn[CORDIC_STEPS] + body_sn[CORDIC_STEPS] - flow_c;
			body_s18 <= body_sn[CORDIC_STEPS];
		end
	end

	// stages 19 to 35: sine of attack, sine and cosine of body angle
	logic signed [15:0] s_s35, c_s35, sb_s35, cb_s35;

	csaf_sincos u_attack (
		.clk     (clk),
		.en      (en),
		.angle   (attack_s18),
		.sin_val (s_s35),
		.cos_val (c_s35)
	);

	csaf_sincos u_body (
		.clk     (clk),
		.en      (en),
		.angle   (body_s18),
		.sin_val (sb_s35),
		.cos_val (cb_s35)
	);

	// stage 36: scaled lift magnitude and sine squared
	logic [63:0]        lift_prod;
	logic signed [31:0] s_sq;
	logic [47:0]        t_s36, v2_s36;
	logic [28:0]        ssq_s36;
	logic signed [15:0] s_s36, sb_s36, cb_s36;

	assign lift_prod = (64'(v2_sn[V2_LEN-1]) * 64'(lc_q)) + 64'd32768;
	assign s_sq = s_s35 * s_s35;

	always_ff @(posedge clk) begin
		if (en) begin
			t_s36 <= lift_prod[63:16];
			ssq_s36 <= s_sq[28:0];
			s_s36 <= s_s35;
			sb_s36 <= sb_s35;
			cb_s36 <= cb_s35;
			v2_s36 <= v2_sn[V2_LEN-1];
		end
	end

	// stage 37: lift and drag coefficient
	logic signed [64:0] lift_full, lift_rnd;
	logic signed [16:0] dd;
	logic signed [46:0] coef_full, coef_rnd;
	logic signed [49:0] lift_s37;
	logic signed [17:0] coef_s37;
	logic [47:0]        v2_s37;
	logic signed [15:0] sb_s37, cb_s37;

	always_comb begin
		lift_full = $signed({1'b0, t_s36}) * s_s36;
		lift_rnd = (lift_full + 65'sd8192) >>> 14;
		dd = $signed({1'b0, dv_q}) - $signed({1'b0, dh_q});
		coef_full = dd * $signed({1'b0, ssq_s36});
		coef_rnd = (coef_full + 47'sd134217728) >>> 28;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lift_s37 <= -$signed(lift_rnd[49:0]);
			coef_s37 <= $signed({2'b00, dh_q}) + $signed(coef_rnd[17:0]);
			v2_s37 <= v2_s36;
			sb_s37 <= sb_s36;
			cb_s37 <= cb_s36;
		end
	end

	// stage 38: drag
	logic signed [66:0] drag_full, drag_rnd;
	logic signed [49:0] drag_s38, lift_s38;
	logic signed [15:0] sb_s38, cb_s38;

	always_comb begin
		drag_full = $signed({1'b0, v2_s37}) * coef_s37;
		drag_rnd = (drag_full + 67'sd32768) >>> 16;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			drag_s38 <= -$signed(drag_rnd[49:0]);
			lift_s38 <= lift_s37;
			sb_s38 <= sb_s37;
			cb_s38 <= cb_s37;
		end
	end

	// stage 39: rotation products
	logic signed [65:0] dc_s39, ls_s39, ds_s39, lc_s39;

	always_ff @(posedge clk) begin
		if (en) begin
			dc_s39 <= drag_s38 * cb_s38;
			ls_s39 <= lift_s38 * sb_s38;
			ds_s39 <= drag_s38 * sb_s38;
			lc_s39 <= lift_s38 * cb_s38;
		end
	end

	// stage 40: round and saturate into the output register
	function automatic logic signed [47:0] sat48(input logic signed [66:0] v);
		logic signed [47:0] r;
		if (v > 67'sh0_7FFF_FFFF_FFFF)
			r = 48'sh7FFF_FFFF_FFFF;
		else if (v < -67'sh0_8000_0000_0000)
			r = -48'sh8000_0000_0000;
		else
			r = v[47:0];
		return r;
	endfunction

	logic signed [66:0] fx_sum, fy_sum, fx_rnd, fy_rnd;
	result_t            result_s40;

	always_comb begin
		fx_sum = {dc_s39[65], dc_s39} + {ls_s39[65], ls_s39};
		fy_sum = {ds_s39[65], ds_s39} - {lc_s39[65], lc_s39};
		fx_rnd = (fx_sum + 67'sd8192) >>> 14;
		fy_rnd = (fy_sum + 67'sd8192) >>> 14;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_s40.force_x <= sat48(fx_rnd);
			result_s40.force_y <= sat48(fy_rnd);
		end
	end

	assign result_data = result_s40;

	// checks
	a_stall_only_from_output: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> (result_valid && !result_ready))
		else $error("pipeline stalled without a waiting result");

	a_cosine_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_sn[35] |-> (c_s35 <= 16'sd16384 && c_s35 >= -16'sd16384))
		else $error("attack cosine outside unity");

	a_sine_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_sn[36] |-> (s_s36 <= 16'sd16384 && s_s36 >= -16'sd16384))
		else $error("attack sine outside unity");

	a_coef_non_negative: assert property (@(posedge clk) disable iff (!arst_n)
		vld_sn[37] |-> (coef_s37 >= 0))
		else $error("drag coefficient went negative");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(!en && vld_sn[39]) |=> vld_sn[39])
		else $error("stage lost an item during a stall");

endmodule

`default_nettype wire
